FILE: rtl/swcs_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// swcs_pkg
// Shared constants and types for the sliding window channel statistics block.
// ---------------------------------------------------------------------------
package swcs_pkg;

	localparam int unsigned WINDOW_DEFAULT = 10;
	localparam int unsigned NUM_CH         = 7;
	localparam int unsigned IN_W           = 16;
	localparam int unsigned VAL_W          = 17;
	localparam int unsigned NUM_ACCEL      = 3;
	localparam int unsigned CH_W           = 3;
	localparam int unsigned MEAN_W         = 25;
	localparam int unsigned QUO_W          = 24;
	localparam int unsigned FRAC_W         = 8;
	localparam int unsigned OUT_SUM_W      = 21;
	localparam int unsigned OUT_CNT_W      = 4;
	localparam int unsigned IN_TDATA_W     = NUM_CH * IN_W;
	localparam int unsigned OUT_TDATA_W    = 88;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WALK,
		ST_DIV,
		ST_EMIT
	} state_t;

endpackage : swcs_pkg
`default_nettype wire

FILE: rtl/swcs_win.sv
`default_nettype none
// ---------------------------------------------------------------------------
// swcs_win
// Circular sample memory with a walker that accumulates sum, maximum and
// minimum of all seven channels over the occupied slots.
// ---------------------------------------------------------------------------
module swcs_win #(
	parameter int unsigned WINDOW = swcs_pkg::WINDOW_DEFAULT,
	localparam int unsigned CntW = $clog2(WINDOW + 1),
	localparam int unsigned SumW = swcs_pkg::VAL_W + CntW
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                wr_en,
	input  wire logic [swcs_pkg::IN_TDATA_W-1:0]     wr_data,
	input  wire logic                                walk_start,
	output logic                                     walk_done,
	output logic [CntW-1:0]                          fill_cnt,
	output logic signed [SumW-1:0]                   sum   [swcs_pkg::NUM_CH],
	output logic signed [swcs_pkg::VAL_W-1:0]        max_v [swcs_pkg::NUM_CH],
	output logic signed [swcs_pkg::VAL_W-1:0]        min_v [swcs_pkg::NUM_CH]
);
	import swcs_pkg::*;

	localparam int unsigned AddrW = (WINDOW > 1) ? $clog2(WINDOW) : 1;

	logic [IN_TDATA_W-1:0] mem_q [WINDOW];
	logic [AddrW-1:0]      wr_slot_q;
	logic [CntW-1:0]       fill_q;
	logic [AddrW-1:0]      rd_idx_q;
	logic                  walking_q;
	logic [IN_TDATA_W-1:0] rd_data_s1;
	logic                  rd_vld_s1;
	logic                  rd_first_s1;
	logic                  rd_last_s1;
	logic                  done_q;
	logic                  rd_is_last;

	assign rd_is_last = (CntW'(rd_idx_q) == fill_q - CntW'(1));

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_slot_q] <= wr_data;
		end
		rd_data_s1 <= mem_q[rd_idx_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_slot_q   <= '0;
			fill_q      <= '0;
			rd_idx_q    <= '0;
			walking_q   <= 1'b0;
			rd_vld_s1   <= 1'b0;
			rd_first_s1 <= 1'b0;
			rd_last_s1  <= 1'b0;
			done_q      <= 1'b0;
		end else begin
			if (wr_en) begin
				wr_slot_q <= (wr_slot_q == AddrW'(WINDOW - 1)) ? '0 : wr_slot_q + AddrW'(1);
				if (fill_q != CntW'(WINDOW)) begin
					fill_q <= fill_q + CntW'(1);
				end
			end
			if (walk_start) begin
				walking_q <= 1'b1;
				rd_idx_q  <= '0;
			end else if (walking_q) begin
				rd_idx_q <= rd_idx_q + AddrW'(1);
				if (rd_is_last) begin
					walking_q <= 1'b0;
				end
			end
			rd_vld_s1   <= walking_q;
			rd_first_s1 <= walking_q && (rd_idx_q == '0);
			rd_last_s1  <= walking_q && rd_is_last;
			done_q      <= rd_vld_s1 && rd_last_s1;
		end
	end

	for (genvar c = 0; c < NUM_CH; c++) begin : g_lane
		logic signed [VAL_W-1:0] val;
		logic [IN_W-1:0]         raw;

		assign raw = rd_data_s1[c*IN_W +: IN_W];
		// Accelerometer axes are signed, colour levels are unsigned.
		assign val = (c < NUM_ACCEL) ? {raw[IN_W-1], raw} : {1'b0, raw};

		always_ff @(posedge clk) begin
			if (rd_vld_s1) begin
				if (rd_first_s1) begin
					sum[c]   <= SumW'(val);
					max_v[c] <= val;
					min_v[c] <= val;
				end else begin
					sum[c] <= sum[c] + SumW'(val);
					if (val > max_v[c]) begin
						max_v[c] <= val;
					end
					if (val < min_v[c]) begin
						min_v[c] <= val;
					end
				end
			end
		end
	end

	assign walk_done = done_q;
	assign fill_cnt  = fill_q;

endmodule : swcs_win
`default_nettype wire

FILE: rtl/swcs_div.sv
`default_nettype none
// ---------------------------------------------------------------------------
// swcs_div
// Serial restoring divider: window sum times 256 over the sample count,
// one quotient bit per cycle, truncated toward zero.
// ---------------------------------------------------------------------------
module swcs_div #(
	parameter int unsigned WINDOW = swcs_pkg::WINDOW_DEFAULT,
	localparam int unsigned CntW = $clog2(WINDOW + 1),
	localparam int unsigned SumW = swcs_pkg::VAL_W + CntW
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                start,
	input  wire logic signed [SumW-1:0]              sum,
	input  wire logic [CntW-1:0]                     count,
	output logic                                     done,
	output logic signed [swcs_pkg::MEAN_W-1:0]       mean_q8
);
	import swcs_pkg::*;

	localparam int unsigned StepW = $clog2(QUO_W + 1);

	logic [SumW-1:0]  mag;
	logic [CntW-1:0]  rem_q;
	logic [QUO_W-1:0] quo_q;
	logic [CntW-1:0]  den_q;
	logic             neg_q;
	logic [StepW-1:0] step_q;
	logic             busy_q;
	logic             done_q;
	logic [CntW:0]    trial;
	logic             fits;

	assign mag   = sum[SumW-1] ? (~sum + 1'b1) : sum;
	assign trial = {rem_q, quo_q[QUO_W-1]};
	assign fits  = (trial >= {1'b0, den_q});

	// The quotient is known to stay below 2**24 (mean of 16-bit values times
	// 256), so the bits of the dividend above that form a remainder that is
	// already smaller than the divisor.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= mag[IN_W+CntW-1:IN_W];
			quo_q <= {mag[IN_W-1:0], {FRAC_W{1'b0}}};
			den_q <= count;
			neg_q <= sum[SumW-1];
		end else if (busy_q) begin
			rem_q <= fits ? CntW'(trial - {1'b0, den_q}) : trial[CntW-1:0];
			quo_q <= {quo_q[QUO_W-2:0], fits};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + StepW'(1);
				if (step_q == StepW'(QUO_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done    = done_q;
	assign mean_q8 = neg_q ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});

endmodule : swcs_div
`default_nettype wire

FILE: rtl/sliding_window_channel_stats.sv
`default_nettype none
// ---------------------------------------------------------------------------
// sliding_window_channel_stats
// Sliding window sum, maximum, minimum and mean over seven sensor channels.
// ---------------------------------------------------------------------------
// Each item on the s_axis channel is one sensor sample: accelerometer X, Y
// and Z (signed) and the clear, red, green and blue colour levels (unsigned).
// The sample is written into a circular memory of WINDOW slots, replacing the
// oldest once the window is full. For every sample the block sends seven
// items on m_axis, one per channel in the order X, Y, Z, clear, red, green,
// blue, with tlast set on the blue item.
// Work per sample: the sample is written at acceptance, the walker then reads
// one memory slot per cycle and updates all seven channels at once, then
// seven serial dividers produce the means, and the seven items go out one per
// cycle while m_axis does not stall.
// s_axis_tready is high only while the block is idle; it goes high again as
// soon as the blue item sits in the output register, so a stalled receiver
// holds the block while any of the seven items is still to be loaded.
// Reset empties the window (fill count and write slot go to zero) and drops
// any item in flight; the memory itself is not cleared.
// ---------------------------------------------------------------------------
module sliding_window_channel_stats #(
	parameter int unsigned WINDOW = swcs_pkg::WINDOW_DEFAULT
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               s_axis_tvalid,
	output logic                                    s_axis_tready,
	// accel_x, accel_y, accel_z, clear_level, red_level, green_level,
	// blue_level, 16 bits each from bit 0 up
	input  wire logic [swcs_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
	output logic                                    m_axis_tvalid,
	input  wire logic                               m_axis_tready,
	// channel[2:0], mean_q8[27:3], max_value[44:28], min_value[61:45],
	// window_sum[82:62], sample_count[86:83], zero pad[87]
	output logic [swcs_pkg::OUT_TDATA_W-1:0]        m_axis_tdata,
	// last_of_run: set on the blue result of each sample
	output logic                                    m_axis_tlast
);
	import swcs_pkg::*;

	localparam int unsigned CntW = $clog2(WINDOW + 1);
	localparam int unsigned SumW = VAL_W + CntW;

	state_t                  state_q;
	state_t                  state_d;
	logic [CH_W-1:0]         ch_q;
	logic [CH_W-1:0]         ch_d;
	logic                    accept;
	logic                    out_free;
	logic                    load;
	logic                    div_start;
	logic                    walk_done;
	logic [CntW-1:0]         fill_cnt;
	logic signed [SumW-1:0]  sum   [NUM_CH];
	logic signed [VAL_W-1:0] max_v [NUM_CH];
	logic signed [VAL_W-1:0] min_v [NUM_CH];
	logic signed [MEAN_W-1:0] mean [NUM_CH];
	logic [NUM_CH-1:0]       lane_done;
	logic                    div_done;
	logic [SumW+OUT_SUM_W-1:0] sum_ext;
	logic [CntW+OUT_CNT_W-1:0] cnt_ext;
	logic                    out_valid_q;
	logic [OUT_TDATA_W-1:0]  out_data_q;
	logic                    out_last_q;

	assign accept   = s_axis_tvalid && s_axis_tready;
	assign out_free = !out_valid_q || m_axis_tready;
	assign div_done = &lane_done;

	swcs_win #(
		.WINDOW(WINDOW)
	) u_win (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr_en     (accept),
		.wr_data   (s_axis_tdata),
		.walk_start(accept),
		.walk_done (walk_done),
		.fill_cnt  (fill_cnt),
		.sum       (sum),
		.max_v     (max_v),
		.min_v     (min_v)
	);

	for (genvar c = 0; c < NUM_CH; c++) begin : g_div
		swcs_div #(
			.WINDOW(WINDOW)
		) u_div (
			.clk    (clk),
			.arst_n (arst_n),
			.start  (div_start),
			.sum    (sum[c]),
			.count  (fill_cnt),
			.done   (lane_done[c]),
			.mean_q8(mean[c])
		);
	end

	// Sequencer: idle, walk the window, divide, then hand out the seven items.
	always_comb begin
		state_d       = state_q;
		ch_d          = ch_q;
		s_axis_tready = 1'b0;
		div_start     = 1'b0;
		load          = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_axis_tready = 1'b1;
				if (s_axis_tvalid) begin
					state_d = ST_WALK;
				end
			end
			ST_WALK: begin
				if (walk_done) begin
					div_start = 1'b1;
					state_d   = ST_DIV;
				end
			end
			ST_DIV: begin
				if (div_done) begin
					ch_d    = '0;
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (out_free) begin
					load = 1'b1;
					ch_d = ch_q + CH_W'(1);
					if (ch_q == CH_W'(NUM_CH - 1)) begin
						state_d = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ch_q    <= '0;
		end else begin
			state_q <= state_d;
			ch_q    <= ch_d;
		end
	end

	// Wide windows report the sum and count modulo their field widths.
	assign sum_ext = {{OUT_SUM_W{sum[ch_q][SumW-1]}}, sum[ch_q]};
	assign cnt_ext = {{OUT_CNT_W{1'b0}}, fill_cnt};

	// Output register: parts the receiver from the sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_data_q <= {1'b0, cnt_ext[OUT_CNT_W-1:0], sum_ext[OUT_SUM_W-1:0],
				min_v[ch_q], max_v[ch_q], mean[ch_q], ch_q};
			out_last_q <= (ch_q == CH_W'(NUM_CH - 1));
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tlast  = out_last_q;

endmodule : sliding_window_channel_stats
`default_nettype wire

FILE: tb/sv/tb_sliding_window_channel_stats.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_sliding_window_channel_stats
// Self-checking testbench for the sliding window channel statistics block.
// ---------------------------------------------------------------------------
// Sensor samples go in on the s_axis side, and every sample must produce seven
// channel results on m_axis. A scoreboard class keeps its own copy of the
// sample window. For each accepted sample it works out the sum, maximum,
// minimum, count and truncated Q8 mean of every channel, and it checks each
// result item field by field in arrival order. The run starts with directed
// samples that fill and wrap the window at the extreme field values. Random
// samples follow under several pacing phases, and one phase holds the output
// off for a long stretch so that the block backs up and stalls its input.
// ---------------------------------------------------------------------------
module tb_sliding_window_channel_stats;
	import swcs_pkg::*;

	localparam int unsigned WIN_DEPTH    = WINDOW_DEFAULT;
	localparam int unsigned RANDOM_ITEMS = 400;
	localparam int unsigned NUM_PHASES   = 5;
	localparam int unsigned HOLD_CYCLES  = 400;
	localparam int unsigned STALL_LIMIT  = 3000;
	localparam int unsigned DRAIN_CYCLES = 80;
	localparam int unsigned MAX_REPORTS  = 40;

	// One channel result as the block should send it, each field as raw bits.
	typedef struct packed {
		logic [CH_W-1:0]      channel;
		logic [MEAN_W-1:0]    mean_q8;
		logic [VAL_W-1:0]     max_value;
		logic [VAL_W-1:0]     min_value;
		logic [OUT_SUM_W-1:0] window_sum;
		logic [OUT_CNT_W-1:0] sample_count;
		logic                 last_of_run;
	} chan_stats_t;

	// Scoreboard: a private copy of the window and the queue of channel
	// results that the block still owes.
	class window_stats_board;
		int          slot_val [WIN_DEPTH][NUM_CH];
		int unsigned held;
		int unsigned next_slot;
		chan_stats_t owed_q [$];
		int unsigned errors;
		int unsigned samples;
		int unsigned results;

		function new();
			held      = 0;
			next_slot = 0;
			errors    = 0;
			samples   = 0;
			results   = 0;
		endfunction

		function void report(input string msg);
			if (errors < MAX_REPORTS) begin
				$display("ERROR at %0t: %s", $time, msg);
			end
			errors++;
		endfunction

		function int unsigned pending();
			return owed_q.size();
		endfunction

		// Store one accepted sample and queue the seven results it causes.
		function void note_sample(input logic [IN_TDATA_W-1:0] td);
			chan_stats_t r;
			longint      total;
			longint      mean;
			int          hi;
			int          lo;
			int          v;
			for (int ch = 0; ch < NUM_CH; ch++) begin
				// Accelerometer axes are signed, colour levels are not.
				if (ch < NUM_ACCEL) begin
					v = int'($signed(td[ch*IN_W +: IN_W]));
				end else begin
					v = int'(td[ch*IN_W +: IN_W]);
				end
				slot_val[next_slot][ch] = v;
			end
			next_slot = (next_slot + 1) % WIN_DEPTH;
			if (held < WIN_DEPTH) begin
				held++;
			end
			samples++;

			// Only slots that hold a sample are visited, so nothing
			// unwritten is ever read.
			for (int ch = 0; ch < NUM_CH; ch++) begin
				total = 0;
				hi    = 0;
				lo    = 0;
				for (int i = 0; i < held; i++) begin
					v     = slot_val[i][ch];
					total += v;
					if (i == 0 || v > hi) begin
						hi = v;
					end
					if (i == 0 || v < lo) begin
						lo = v;
					end
				end
				// Signed division truncates toward zero, as the block must.
				mean           = (total * 256) / longint'(held);
				r.channel      = ch[CH_W-1:0];
				r.mean_q8      = mean[MEAN_W-1:0];
				r.max_value    = hi[VAL_W-1:0];
				r.min_value    = lo[VAL_W-1:0];
				r.window_sum   = total[OUT_SUM_W-1:0];
				r.sample_count = held[OUT_CNT_W-1:0];
				r.last_of_run  = (ch == NUM_CH - 1);
				owed_q.push_back(r);
			end
		endfunction

		function void cmp_field(input string name, input logic [31:0] got,
				input logic [31:0] want, input chan_stats_t exp_r);
			if (got !== want) begin
				report($sformatf("sample %0d channel %0d %s: got 0x%0h, want 0x%0h",
					samples, exp_r.channel, name, got, want));
			end
		endfunction

		// Compare one accepted result item with the oldest owed result.
		function void check_result(input logic [OUT_TDATA_W-1:0] td, input logic last);
			chan_stats_t want;
			results++;
			if (owed_q.size() == 0) begin
				report($sformatf("result for channel %0d with none outstanding", td[2:0]));
				return;
			end
			want = owed_q.pop_front();
			cmp_field("channel",      32'(td[2:0]),   32'(want.channel),      want);
			cmp_field("mean_q8",      32'(td[27:3]),  32'(want.mean_q8),      want);
			cmp_field("max_value",    32'(td[44:28]), 32'(want.max_value),    want);
			cmp_field("min_value",    32'(td[61:45]), 32'(want.min_value),    want);
			cmp_field("window_sum",   32'(td[82:62]), 32'(want.window_sum),   want);
			cmp_field("sample_count", 32'(td[86:83]), 32'(want.sample_count), want);
			cmp_field("tlast",        32'(last),      32'(want.last_of_run),  want);
		endfunction
	endclass

	logic                   clk;
	logic                   arst_n;
	logic                   s_axis_tvalid;
	logic                   s_axis_tready;
	logic [IN_TDATA_W-1:0]  s_axis_tdata;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;
	logic                   m_axis_tlast;

	// Pacing knobs, in percent of cycles. The main sequence sets them per
	// phase; the sender task and the receiver process read them.
	int unsigned send_idle_pct;
	int unsigned recv_stall_pct;
	// The main sequence bumps hold_reqs; the receiver serves each request
	// with one long stretch of tready low.
	int unsigned hold_reqs;

	window_stats_board sb;

	sliding_window_channel_stats #(
		.WINDOW (WIN_DEPTH)
	) i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	initial begin
		clk = 1'b0;
		forever begin
			#1 clk = ~clk;
		end
	end

	// A random level with the extremes of both encodings mixed in often.
	function automatic logic [IN_W-1:0] rand_level();
		case ($urandom_range(0, 15))
			0:       return 16'h8000;
			1:       return 16'h7FFF;
			2:       return 16'h0000;
			3:       return 16'hFFFF;
			4:       return 16'h0001;
			default: return IN_W'($urandom);
		endcase
	endfunction

	// Offer one sample, starting and ending at a falling edge. Random idle
	// cycles come first, then the item is held until it is taken.
	task automatic send_sample(input logic [IN_TDATA_W-1:0] td);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			s_axis_tvalid = 1'b0;
			s_axis_tdata  = IN_TDATA_W'({4{$urandom}});
			@(negedge clk);
		end
		s_axis_tdata  = td;
		s_axis_tvalid = 1'b1;
		do begin
			@(posedge clk);
		end while (!s_axis_tready);
		sb.note_sample(td);
		@(negedge clk);
	endtask

	// Receiver: random stalls, plus the long hold-off when one is asked for.
	initial begin
		int unsigned hold_served;
		int unsigned hold_left;
		hold_served   = 0;
		hold_left     = 0;
		m_axis_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_served != hold_reqs) begin
				hold_served++;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left != 0) begin
				hold_left--;
				m_axis_tready = 1'b0;
			end else begin
				m_axis_tready = ($urandom_range(0, 99) >= recv_stall_pct);
			end
		end
	end

	// Every accepted result item goes to the scoreboard.
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			sb.check_result(m_axis_tdata, m_axis_tlast);
		end
	end

	// Watchdog: too many cycles in a row without any handshake ends the run.
	initial begin
		int unsigned quiet;
		quiet = 0;
		forever begin
			@(posedge clk);
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
				quiet = 0;
			end else if (arst_n) begin
				quiet++;
			end
			if (quiet >= STALL_LIMIT) begin
				$display("Watchdog: no item moved for %0d cycles, %0d results outstanding",
					quiet, sb.pending());
				$display("== FAIL ==");
				$finish;
			end
		end
	end

	initial begin
		logic [IN_TDATA_W-1:0] td;
		logic [IN_W-1:0]       acc_v;
		logic [IN_W-1:0]       col_v;
		int unsigned           per_phase;

		sb             = new();
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		hold_reqs      = 0;
		s_axis_tvalid  = 1'b0;
		s_axis_tdata   = '0;
		arst_n         = 1'b0;
		repeat (2) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed part, full speed. Eleven samples of the most negative
		// acceleration with full-scale colour fill and wrap the window at the
		// extreme sums. Eleven more swap to the opposite extremes, which also
		// drives the window through a full turnover. Two alternating bit
		// patterns close it off.
		for (int k = 0; k < 24; k++) begin
			if (k < 11) begin
				acc_v = 16'h8000;
				col_v = 16'hFFFF;
			end else if (k < 22) begin
				acc_v = 16'h7FFF;
				col_v = 16'h0000;
			end else if (k == 22) begin
				acc_v = 16'h5555;
				col_v = 16'hAAAA;
			end else begin
				acc_v = 16'hAAAA;
				col_v = 16'h5555;
			end
			for (int ch = 0; ch < NUM_CH; ch++) begin
				td[ch*IN_W +: IN_W] = (ch < NUM_ACCEL) ? acc_v : col_v;
			end
			send_sample(td);
		end

		// Random part in pacing phases: no idling, a mostly idle sender,
		// a mostly stalled receiver, both sides idling now and then, and a
		// final unpaced phase that opens with the long output hold-off.
		per_phase = RANDOM_ITEMS / NUM_PHASES;
		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			case (ph)
				1: begin
					send_idle_pct  = 86;
					recv_stall_pct = 0;
				end
				2: begin
					send_idle_pct  = 0;
					recv_stall_pct = 86;
				end
				3: begin
					send_idle_pct  = 24;
					recv_stall_pct = 24;
				end
				default: begin
					send_idle_pct  = 0;
					recv_stall_pct = 0;
				end
			endcase
			if (ph == NUM_PHASES - 1) begin
				hold_reqs++;
			end
			for (int n = 0; n < per_phase; n++) begin
				for (int ch = 0; ch < NUM_CH; ch++) begin
					td[ch*IN_W +: IN_W] = rand_level();
				end
				send_sample(td);
			end
		end
		s_axis_tvalid = 1'b0;

		// Drain, then give the block time to show any stray result.
		while (sb.pending() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (sb.pending() != 0) begin
			sb.report($sformatf("%0d results never arrived", sb.pending()));
		end
		$display("Covered %0d samples and %0d channel results through window fill and wrap,",
			sb.samples, sb.results);
		$display("five pacing phases and a %0d cycle output hold-off; %0d mismatches.",
			HOLD_CYCLES, sb.errors);
		if (sb.errors == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
